### rtl/nmea_gga_vtg_field_parser_unit_assert.svh
// -----------------------------------------------------------------------------
// NMEA field parser assertion macros
// Concurrent assertion wrappers; they expand to nothing under synthesis.
// -----------------------------------------------------------------------------
`ifndef NMEA_GGA_VTG_FIELD_PARSER_UNIT_ASSERT_SVH
`define NMEA_GGA_VTG_FIELD_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset
`define NGVFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition must never be seen at a rising edge outside reset
`define NGVFP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define NGVFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define NGVFP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### rtl/ngvfp_pkg.sv
// -----------------------------------------------------------------------------
// NMEA field parser package
// Character codes, sizes, field codes, result record and decode helpers.
// -----------------------------------------------------------------------------
`default_nettype none

package ngvfp_pkg;

  // Sentence limits
  localparam int unsigned MaxLine   = 80;
  localparam int unsigned MaxDigits = 9;
  localparam int unsigned FracCap   = (MaxDigits < 15) ? MaxDigits : 15;
  localparam int unsigned LineW     = $clog2(MaxLine + 1);

  // Result field widths
  localparam int unsigned LeadW     = 10;
  localparam int unsigned MidW      = 7;
  localparam int unsigned MantissaW = 30;
  localparam int unsigned FracW     = 4;
  localparam int unsigned CntW      = 4;

  // Mantissa accumulator: wide enough for 10^MaxDigits - 1 and the output
  localparam logic [63:0] PowTenMax = 64'd10 ** MaxDigits;
  localparam logic [63:0] PowTenLim = 64'd10 ** (MaxDigits - 1);
  localparam int unsigned MantBits  = $clog2(PowTenMax);
  localparam int unsigned AccW      = (MantBits > MantissaW) ? MantBits : MantissaW;

  // Characters
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChPoint  = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChA      = 8'h41;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChT      = 8'h54;
  localparam logic [7:0] ChV      = 8'h56;

  typedef enum logic {
    PhaseIdle,
    PhaseBody
  } phase_e;

  typedef enum logic [1:0] {
    KindNone,
    KindGga,
    KindVtg
  } kind_e;

  typedef enum logic [3:0] {
    FcTime,
    FcLat,
    FcLatHemi,
    FcLon,
    FcLonHemi,
    FcFix,
    FcSats,
    FcHdop,
    FcAlt,
    FcCourse,
    FcCourseRef,
    FcSpeed,
    FcUnit
  } field_code_e;

  typedef struct packed {
    logic        vld;
    field_code_e code;
  } code_sel_t;

  typedef struct packed {
    field_code_e            code;
    logic                   empty;
    logic [LeadW-1:0]       lead;
    logic [MidW-1:0]        mid;
    logic [MantissaW-1:0]   mant;
    logic [FracW-1:0]       frac;
    logic [7:0]             chr;
    logic                   send;
  } res_t;

  // Sentence type from the three header characters
  function automatic kind_e kind_of(input logic [7:0] c0, input logic [7:0] c1,
                                    input logic [7:0] c2);
    kind_e k;
    k = KindNone;
    if (c0 == ChG && c1 == ChG && c2 == ChA) begin
      k = KindGga;
    end else if (c0 == ChV && c1 == ChT && c2 == ChG) begin
      k = KindVtg;
    end
    return k;
  endfunction

  // Field code of a field index within a sentence type
  function automatic code_sel_t code_of(input kind_e kind, input logic [CntW-1:0] idx);
    code_sel_t s;
    s.vld  = 1'b0;
    s.code = FcTime;
    if (kind == KindGga && idx >= 4'd1 && idx <= 4'd9) begin
      s.vld  = 1'b1;
      s.code = field_code_e'(idx - 4'd1);
    end else if (kind == KindVtg) begin
      unique case (idx)
        4'd1:    begin s.vld = 1'b1; s.code = FcCourse;    end
        4'd2:    begin s.vld = 1'b1; s.code = FcCourseRef; end
        4'd7:    begin s.vld = 1'b1; s.code = FcSpeed;     end
        4'd8:    begin s.vld = 1'b1; s.code = FcUnit;      end
        default: begin s.vld = 1'b0; s.code = FcTime;      end
      endcase
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/ngvfp_in_stage.sv
// -----------------------------------------------------------------------------
// NMEA field parser input register
// Holds one received byte until the parser stage takes it.
// -----------------------------------------------------------------------------
`default_nettype none

module ngvfp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       take_i,
  output logic            vld_o,
  output logic [7:0]      byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;

  // Accept while empty or while the held item leaves this cycle
  assign in_ready_o = !vld_q || take_i;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Load the byte on acceptance
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

`default_nettype wire

### rtl/ngvfp_parser.sv
// -----------------------------------------------------------------------------
// NMEA field parser core
// Sentence framing, header decode and per-field accumulation, one byte a step.
// -----------------------------------------------------------------------------
`default_nettype none

`include "nmea_gga_vtg_field_parser_unit_assert.svh"

module ngvfp_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  output logic             res_vld_o,
  output ngvfp_pkg::res_t  res_o
);

  localparam int unsigned LineW = ngvfp_pkg::LineW;
  localparam int unsigned AccW  = ngvfp_pkg::AccW;
  localparam int unsigned LeadW = ngvfp_pkg::LeadW;
  localparam int unsigned MidW  = ngvfp_pkg::MidW;
  localparam int unsigned CntW  = ngvfp_pkg::CntW;
  localparam int unsigned FracW = ngvfp_pkg::FracW;

  localparam logic [AccW-1:0]  DigLim  = AccW'(ngvfp_pkg::PowTenLim);
  localparam logic [AccW-1:0]  SatVal  = AccW'(ngvfp_pkg::PowTenMax - 64'd1);
  localparam logic [FracW-1:0] FracTop = FracW'(ngvfp_pkg::FracCap);
  localparam logic [LineW-1:0] LineTop = LineW'(ngvfp_pkg::MaxLine);
  localparam logic [CntW-1:0]  CntTop  = '1;

  ngvfp_pkg::phase_e phase_q, phase_d;
  ngvfp_pkg::kind_e  kind_q, kind_d;
  logic [7:0]        hdr_q [3];
  logic [7:0]        hdr_d [3];
  logic [CntW-1:0]   fld_q, fld_d;
  logic [CntW-1:0]   chr_cnt_q, chr_cnt_d;
  logic [LineW-1:0]  line_q, line_d;
  logic [LeadW-1:0]  lead_q, lead_d;
  logic [MidW-1:0]   mid_q, mid_d;
  logic [AccW-1:0]   mant_q, mant_d;
  logic [FracW-1:0]  frac_q, frac_d;
  logic              point_q, point_d;
  logic [7:0]        first_q, first_d;
  logic              halt_q, halt_d;

  // Character class and digit value
  logic            is_star, is_comma, is_point, dig_ok;
  logic [3:0]      dig;
  logic [LeadW-1:0] lead_x10;
  logic [MidW-1:0]  mid_x10;
  logic [AccW-1:0]  mant_x10;

  assign is_star  = (byte_i == ngvfp_pkg::ChStar);
  assign is_comma = (byte_i == ngvfp_pkg::ChComma);
  assign is_point = (byte_i == ngvfp_pkg::ChPoint);
  assign dig_ok   = (byte_i >= ngvfp_pkg::ChZero) && (byte_i <= ngvfp_pkg::ChNine);
  assign dig      = 4'(byte_i - ngvfp_pkg::ChZero);
  assign lead_x10 = (lead_q << 3) + (lead_q << 1) + LeadW'(dig);
  assign mid_x10  = (mid_q << 3) + (mid_q << 1) + MidW'(dig);
  assign mant_x10 = (mant_q << 3) + (mant_q << 1) + AccW'(dig);

  // Next state and result
  always_comb begin
    ngvfp_pkg::code_sel_t sel;
    logic use_lead, use_mid, use_int_mant, use_dec, use_first, halt_clr, halt_eff;

    phase_d   = phase_q;
    kind_d    = kind_q;
    hdr_d     = hdr_q;
    fld_d     = fld_q;
    chr_cnt_d = chr_cnt_q;
    line_d    = line_q;
    lead_d    = lead_q;
    mid_d     = mid_q;
    mant_d    = mant_q;
    frac_d    = frac_q;
    point_d   = point_q;
    first_d   = first_q;
    halt_d    = halt_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    sel       = '0;
    use_lead     = 1'b0;
    use_mid      = 1'b0;
    use_int_mant = 1'b0;
    use_dec      = 1'b0;
    use_first    = 1'b0;
    halt_clr     = 1'b0;
    halt_eff     = 1'b0;

    if (step_i) begin
      if (byte_i == ngvfp_pkg::ChDollar) begin
        // Restart a sentence
        phase_d   = ngvfp_pkg::PhaseBody;
        kind_d    = ngvfp_pkg::KindNone;
        hdr_d     = '{default: 8'h00};
        fld_d     = '0;
        chr_cnt_d = '0;
        line_d    = '0;
        lead_d    = '0;
        mid_d     = '0;
        mant_d    = '0;
        frac_d    = '0;
        point_d   = 1'b0;
        first_d   = '0;
        halt_d    = 1'b0;
      end else if (phase_q == ngvfp_pkg::PhaseBody) begin
        if (!is_star && line_q >= LineTop) begin
          // Drop an over-long sentence
          phase_d = ngvfp_pkg::PhaseIdle;
        end else begin
          if (!is_star) begin
            if (line_q == LineW'(2)) hdr_d[0] = byte_i;
            if (line_q == LineW'(3)) hdr_d[1] = byte_i;
            if (line_q == LineW'(4)) hdr_d[2] = byte_i;
            line_d = line_q + LineW'(1);
          end

          if (is_star || is_comma) begin
            // Close the field
            if (fld_q == '0) begin
              kind_d = ngvfp_pkg::kind_of(hdr_d[0], hdr_d[1], hdr_d[2]);
            end
            sel = ngvfp_pkg::code_of(kind_d, fld_q);
            if (sel.vld) begin
              res_vld_o   = 1'b1;
              res_o.code  = sel.code;
              res_o.empty = (chr_cnt_q == '0);
              res_o.send  = is_star;
              if (chr_cnt_q != '0) begin
                res_o.lead = lead_q;
                res_o.mid  = mid_q;
                res_o.mant = mant_q[ngvfp_pkg::MantissaW-1:0];
                res_o.frac = frac_q;
                res_o.chr  = first_q;
              end
            end
            chr_cnt_d = '0;
            lead_d    = '0;
            mid_d     = '0;
            mant_d    = '0;
            frac_d    = '0;
            point_d   = 1'b0;
            first_d   = '0;
            halt_d    = 1'b0;
            if (fld_q != CntTop) fld_d = fld_q + CntW'(1);
            if (is_star) phase_d = ngvfp_pkg::PhaseIdle;
          end else begin
            // Route the character to its window
            sel = ngvfp_pkg::code_of(kind_q, fld_q);
            if (fld_q != '0 && sel.vld) begin
              case (sel.code) inside
                ngvfp_pkg::FcTime: begin
                  if (chr_cnt_q < 4'd2) begin
                    use_lead = 1'b1;
                  end else if (chr_cnt_q < 4'd4) begin
                    use_mid  = 1'b1;
                    halt_clr = (chr_cnt_q == 4'd2);
                  end else if (chr_cnt_q < 4'd8) begin
                    use_dec = 1'b1;
                  end
                end
                ngvfp_pkg::FcLat: begin
                  if (chr_cnt_q < 4'd2) use_lead = 1'b1;
                  else if (chr_cnt_q < 4'd11) use_dec = 1'b1;
                end
                ngvfp_pkg::FcLon: begin
                  if (chr_cnt_q < 4'd3) use_lead = 1'b1;
                  else if (chr_cnt_q < 4'd12) use_dec = 1'b1;
                end
                ngvfp_pkg::FcSats: begin
                  if (chr_cnt_q < 4'd2) use_int_mant = 1'b1;
                end
                ngvfp_pkg::FcLatHemi, ngvfp_pkg::FcLonHemi, ngvfp_pkg::FcFix,
                ngvfp_pkg::FcCourseRef, ngvfp_pkg::FcUnit: begin
                  use_first = (chr_cnt_q == '0);
                end
                default: begin
                  use_dec = 1'b1;
                end
              endcase
            end

            // Integer windows stop at the first non-digit
            if (use_lead || use_mid || use_int_mant) begin
              halt_eff = halt_q && !halt_clr;
              halt_d   = halt_eff;
              if (!halt_eff) begin
                if (!dig_ok) begin
                  halt_d = 1'b1;
                end else if (use_lead) begin
                  lead_d = lead_x10;
                end else if (use_mid) begin
                  mid_d = mid_x10;
                end else begin
                  mant_d = mant_x10;
                end
              end
            end

            // Decimal windows: mark the point, keep digits within range
            if (use_dec) begin
              if (is_point) begin
                point_d = 1'b1;
              end else if (dig_ok) begin
                if (point_q) begin
                  if (mant_q < DigLim && frac_q < FracTop) begin
                    mant_d = mant_x10;
                    frac_d = frac_q + FracW'(1);
                  end
                end else if (mant_q < DigLim) begin
                  mant_d = mant_x10;
                end else begin
                  mant_d = SatVal;
                end
              end
            end

            if (use_first) first_d = byte_i;
            if (chr_cnt_q != CntTop) chr_cnt_d = chr_cnt_q + CntW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ngvfp_pkg::PhaseIdle;
      kind_q    <= ngvfp_pkg::KindNone;
      hdr_q     <= '{default: 8'h00};
      fld_q     <= '0;
      chr_cnt_q <= '0;
      line_q    <= '0;
      lead_q    <= '0;
      mid_q     <= '0;
      mant_q    <= '0;
      frac_q    <= '0;
      point_q   <= 1'b0;
      first_q   <= '0;
      halt_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      hdr_q     <= hdr_d;
      fld_q     <= fld_d;
      chr_cnt_q <= chr_cnt_d;
      line_q    <= line_d;
      lead_q    <= lead_d;
      mid_q     <= mid_d;
      mant_q    <= mant_d;
      frac_q    <= frac_d;
      point_q   <= point_d;
      first_q   <= first_d;
      halt_q    <= halt_d;
    end
  end

  // A result only comes from a step on a field separator
  `NGVFP_ASSERT(a_res_on_sep, clk_i, rst_ni, res_vld_o |-> (step_i && (is_comma || is_star)), "result without a separator byte")
  // The asterisk ends the sentence
  `NGVFP_ASSERT(a_star_ends, clk_i, rst_ni, (step_i && is_star && phase_q == ngvfp_pkg::PhaseBody) |=> (phase_q == ngvfp_pkg::PhaseIdle), "sentence still open after asterisk")
  // Fresh field holds no accumulated value
  `NGVFP_ASSERT(a_fresh_field, clk_i, rst_ni, (chr_cnt_q == '0) |-> (lead_q == '0 && mid_q == '0 && mant_q == '0 && frac_q == '0 && first_q == '0), "empty field holds a value")
  // Line length never passes its limit
  `NGVFP_ASSERT_NEVER(a_line_cap, clk_i, rst_ni, line_q > LineTop, "line length past limit")
  // Fraction count never passes its cap
  `NGVFP_ASSERT_NEVER(a_frac_cap, clk_i, rst_ni, frac_q > FracTop, "fraction count past cap")

endmodule

`default_nettype wire

### rtl/ngvfp_out_stage.sv
// -----------------------------------------------------------------------------
// NMEA field parser result register
// Holds one decoded field until the consumer takes it.
// -----------------------------------------------------------------------------
`default_nettype none

module ngvfp_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             res_vld_i,
  input  wire ngvfp_pkg::res_t  res_i,
  output logic                  space_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ngvfp_pkg::res_t       res_o
);

  logic            vld_q, vld_d;
  ngvfp_pkg::res_t res_q;

  // Free when empty or when the held item leaves this cycle
  assign space_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (space_o) begin
      vld_d = res_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Capture a new result
  always_ff @(posedge clk_i) begin
    if (space_o && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### rtl/nmea_gga_vtg_field_parser_unit.sv
// -----------------------------------------------------------------------------
// NMEA GGA / VTG field parser
// Splits GGA and VTG sentences into decoded fields, one received byte per item.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_ready_o   rx_byte_i
//   out      source     out_valid_o / out_ready_i field_code_o .. sentence_end_o
//
// One byte is taken every cycle while the result register has space; the sentence state is registered.
// A result is offered once its separator byte has passed from the input register
// through the parser decode into the result register.
// Reset clears the sentence state and both valid flags.
// A stalled result holds the parser; the input register still takes one byte.
// -----------------------------------------------------------------------------
`default_nettype none

module nmea_gga_vtg_field_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       field_code_o,
  output logic             field_empty_o,
  output logic [9:0]       lead_value_o,
  output logic [6:0]       mid_value_o,
  output logic [29:0]      mantissa_o,
  output logic [3:0]       frac_digits_o,
  output logic [7:0]       char_value_o,
  output logic             sentence_end_o
);

  logic            byte_vld;
  logic [7:0]      byte_q;
  logic            space;
  logic            step;
  logic            res_vld;
  ngvfp_pkg::res_t res;
  ngvfp_pkg::res_t res_out;

  // Advance a byte when the result register can take its outcome
  assign step = byte_vld && space;

  ngvfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (step),
    .vld_o      (byte_vld),
    .byte_o     (byte_q)
  );

  ngvfp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (byte_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  ngvfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign field_code_o   = res_out.code;
  assign field_empty_o  = res_out.empty;
  assign lead_value_o   = res_out.lead;
  assign mid_value_o    = res_out.mid;
  assign mantissa_o     = res_out.mant;
  assign frac_digits_o  = res_out.frac;
  assign char_value_o   = res_out.chr;
  assign sentence_end_o = res_out.send;

endmodule

`default_nettype wire
